@@ rtl/core/html_tag_strip_entity_decode_top_defines.svh @@
// Assertion macros shared by the HTML text extractor RTL.
// No dependencies; files that check their own logic include this header.
`ifndef HTML_TAG_STRIP_ENTITY_DECODE_TOP_DEFINES_SVH
`define HTML_TAG_STRIP_ENTITY_DECODE_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define HTSED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define HTSED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/htsed_pkg.sv @@
// Package for the HTML text extractor: sequencer states, the request and
// response structs between sequencer and emitter, and the entity tables.
// No dependencies.
package htsed_pkg;

  localparam int NUM_ENT = 10;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_FLUSH,
    ST_REP,
    ST_END
  } seq_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
  } feed_req_t;

  typedef struct packed {
    logic valid;
    logic last;
  } fin_req_t;

  typedef struct packed {
    logic feed_done;
    logic fin_done;
  } emit_rsp_t;

  // Entity names, character k in byte k.
  function automatic logic [63:0] ent_name(input logic [3:0] e);
    logic [63:0] w;
    case (e)
      4'd0:    w = 64'h0000_003B_706D_6126;
      4'd1:    w = 64'h0000_0000_3B74_6C26;
      4'd2:    w = 64'h0000_0000_3B74_6726;
      4'd3:    w = 64'h0000_3B74_6F75_7126;
      4'd4:    w = 64'h0000_003B_3933_2326;
      4'd5:    w = 64'h0000_3B73_6F70_6126;
      4'd6:    w = 64'h0000_3B70_7362_6E26;
      4'd7:    w = 64'h003B_6873_6164_6D26;
      4'd8:    w = 64'h003B_6873_6164_6E26;
      4'd9:    w = 64'h3B70_696C_6C65_6826;
      default: w = 64'h0;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] ent_char(input logic [3:0] e, input logic [2:0] pos);
    logic [63:0] w;
    w = ent_name(e);
    return w[{pos, 3'b000} +: 8];
  endfunction

  function automatic logic [3:0] ent_len(input logic [3:0] e);
    logic [3:0] n;
    case (e)
      4'd0:    n = 4'd5;
      4'd1:    n = 4'd4;
      4'd2:    n = 4'd4;
      4'd3:    n = 4'd6;
      4'd4:    n = 4'd5;
      4'd5:    n = 4'd6;
      4'd6:    n = 4'd6;
      4'd7:    n = 4'd7;
      4'd8:    n = 4'd7;
      4'd9:    n = 4'd8;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  // Replacement text, first byte in the low byte.
  function automatic logic [7:0] rep_char(input logic [3:0] e, input logic [1:0] idx);
    logic [23:0] w;
    case (e)
      4'd0:    w = 24'h000026;
      4'd1:    w = 24'h00003C;
      4'd2:    w = 24'h00003E;
      4'd3:    w = 24'h000022;
      4'd4:    w = 24'h000027;
      4'd5:    w = 24'h000027;
      4'd6:    w = 24'h000020;
      4'd7:    w = 24'h9480E2;
      4'd8:    w = 24'h9380E2;
      4'd9:    w = 24'hA680E2;
      default: w = 24'h0;
    endcase
    return w[{idx, 3'b000} +: 8];
  endfunction

  function automatic logic [1:0] rep_len(input logic [3:0] e);
    logic [1:0] n;
    case (e)
      4'd7, 4'd8, 4'd9: n = 2'd3;
      default:          n = 2'd1;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/core/htsed_emit.sv @@
// Whitespace collapser and output stage of the HTML text extractor.
// Holds one result back so the final one can be marked. Uses htsed_pkg.
`include "html_tag_strip_entity_decode_top_defines.svh"

module htsed_emit import htsed_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  feed_req_t  feed,
  input  fin_req_t   fin,
  output emit_rsp_t  rsp,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_has_char,
  output logic       out_last
);

  logic       pending_r, pending_nxt;
  logic       emitted_r, emitted_nxt;
  logic       held_v_r, held_v_nxt;
  logic [7:0] held_r, held_nxt;
  logic       out_v_r, out_v_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       oh_r, oh_nxt;
  logic       ol_r, ol_nxt;
  logic       slot_free;
  logic       emit_ok;
  logic       is_ws;

  assign slot_free = !out_v_r || out_ready;
  assign emit_ok   = !held_v_r || slot_free;
  assign is_ws     = (feed.ch == CH_SPACE) || ((feed.ch >= CH_TAB) && (feed.ch <= CH_CR));

  always_comb begin
    pending_nxt   = pending_r;
    emitted_nxt   = emitted_r;
    held_v_nxt    = held_v_r;
    held_nxt      = held_r;
    out_v_nxt     = out_v_r && !out_ready;
    ob_nxt        = ob_r;
    oh_nxt        = oh_r;
    ol_nxt        = ol_r;
    rsp.feed_done = 1'b0;
    rsp.fin_done  = 1'b0;
    if (feed.valid) begin
      if (is_ws) begin
        rsp.feed_done = 1'b1;
        if (emitted_r) begin
          pending_nxt = 1'b1;
        end
      end else if (emit_ok) begin
        if (held_v_r) begin
          out_v_nxt = 1'b1;
          ob_nxt    = held_r;
          oh_nxt    = 1'b1;
          ol_nxt    = 1'b0;
        end
        held_v_nxt = 1'b1;
        if (pending_r) begin
          // The collapsed space is held first; feed_done stays low, so the character is fed again.
          held_nxt    = CH_SPACE;
          pending_nxt = 1'b0;
        end else begin
          held_nxt      = feed.ch;
          emitted_nxt   = 1'b1;
          rsp.feed_done = 1'b1;
        end
      end
    end else if (fin.valid) begin
      if (fin.last) begin
        if (slot_free) begin
          out_v_nxt    = 1'b1;
          ob_nxt       = held_v_r ? held_r : 8'h00;
          oh_nxt       = held_v_r;
          ol_nxt       = 1'b1;
          held_v_nxt   = 1'b0;
          pending_nxt  = 1'b0;
          emitted_nxt  = 1'b0;
          rsp.fin_done = 1'b1;
        end
      end else if (!held_v_r) begin
        rsp.fin_done = 1'b1;
      end else if (slot_free) begin
        out_v_nxt    = 1'b1;
        ob_nxt       = held_r;
        oh_nxt       = 1'b1;
        ol_nxt       = 1'b0;
        held_v_nxt   = 1'b0;
        rsp.fin_done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      emitted_r <= 1'b0;
      held_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      emitted_r <= emitted_nxt;
      held_v_r  <= held_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
    ob_r   <= ob_nxt;
    oh_r   <= oh_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_valid    = out_v_r;
  assign out_byte     = ob_r;
  assign out_has_char = oh_r;
  assign out_last     = ol_r;

  `HTSED_ASSERT_NXT(a_doc_end_clears, fin.valid && fin.last && rsp.fin_done, !pending_r && !emitted_r && !held_v_r, "document end left whitespace state behind")
  `HTSED_ASSERT_NXT(a_text_marks_emitted, feed.valid && rsp.feed_done && !is_ws, emitted_r && held_v_r, "text byte did not reach the hold register")
  `HTSED_ASSERT_IMP(a_one_request, 1'b1, !(feed.valid && fin.valid), "feed and finish requested together")

endmodule

@@ rtl/core/htsed_seq.sv @@
// Sequencer of the HTML text extractor: tag stripping, entity look-ahead
// buffer with candidate matching, replay and replacement. Uses htsed_pkg.
`include "html_tag_strip_entity_decode_top_defines.svh"

module htsed_seq import htsed_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output feed_req_t  feed,
  output fin_req_t   fin,
  input  emit_rsp_t  rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  seq_state_t         state_r, state_nxt;
  logic               inside_r, inside_nxt;
  logic               last_r, last_nxt;
  logic [7:0]         cur_r, cur_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [NUM_ENT-1:0] mask_r, mask_nxt;
  logic [IW-1:0]      fidx_r, fidx_nxt;
  logic               ret_end_r, ret_end_nxt;
  logic [3:0]         rsel_r, rsel_nxt;
  logic [1:0]         ridx_r, ridx_nxt;
  logic [7:0]         buf_r [DEPTH];
  logic               wr_en;
  logic [IW-1:0]      wr_idx;
  logic [NUM_ENT-1:0] cand;
  logic               full_hit;
  logic [3:0]         full_e;
  logic               prefix;
  logic               is_bracket;
  logic               take_in;
  logic               flush_end;
  logic               rep_end;

  assign is_bracket = (in_byte == CH_LT) || (in_byte == CH_GT);
  assign take_in    = is_bracket || !inside_r;
  assign flush_end  = (CW'(fidx_r) == (count_r - CW'(1)));
  assign rep_end    = (ridx_r == (rep_len(rsel_r) - 2'd1));

  // Candidate entities that the buffer plus the current byte still spell.
  always_comb begin
    cand     = '0;
    full_hit = 1'b0;
    full_e   = 4'd0;
    for (int e = 0; e < NUM_ENT; e++) begin
      cand[e] = mask_r[e] && (int'(count_r) < int'(ent_len(4'(e)))) &&
                (ent_char(4'(e), count_r[2:0]) == cur_r);
      if (cand[e] && (int'(count_r) + 1 == int'(ent_len(4'(e))))) begin
        full_hit = 1'b1;
        full_e   = 4'(e);
      end
    end
  end

  assign prefix = (|cand) && !full_hit && (int'(count_r) < DEPTH);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = take_in ? ST_DEC : ST_END;
        end
      end
      ST_DEC: begin
        if (count_r == '0) begin
          if ((cur_r == CH_AMP) || rsp.feed_done) begin
            state_nxt = ST_END;
          end
        end else if (full_hit) begin
          state_nxt = ST_REP;
        end else if (prefix) begin
          state_nxt = ST_END;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (rsp.feed_done && flush_end) begin
          state_nxt = ret_end_r ? ST_END : ST_DEC;
        end
      end
      ST_REP: begin
        if (rsp.feed_done && rep_end) begin
          state_nxt = ST_END;
        end
      end
      ST_END: begin
        if (last_r && (count_r != '0)) begin
          state_nxt = ST_FLUSH;
        end else if (rsp.fin_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    inside_nxt  = inside_r;
    last_nxt    = last_r;
    cur_nxt     = cur_r;
    count_nxt   = count_r;
    mask_nxt    = mask_r;
    fidx_nxt    = fidx_r;
    ret_end_nxt = ret_end_r;
    rsel_nxt    = rsel_r;
    ridx_nxt    = ridx_r;
    wr_en       = 1'b0;
    wr_idx      = count_r[IW-1:0];
    feed.valid  = 1'b0;
    feed.ch     = cur_r;
    fin.valid   = 1'b0;
    fin.last    = last_r;
    in_ready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          last_nxt = in_last;
          cur_nxt  = is_bracket ? CH_SPACE : in_byte;
          if (in_byte == CH_LT) begin
            inside_nxt = 1'b1;
          end else if (in_byte == CH_GT) begin
            inside_nxt = 1'b0;
          end
        end
      end
      ST_DEC: begin
        if (count_r == '0) begin
          if (cur_r == CH_AMP) begin
            wr_en     = 1'b1;
            count_nxt = CW'(1);
            mask_nxt  = '1;
          end else begin
            feed.valid = 1'b1;
          end
        end else if (full_hit) begin
          count_nxt = '0;
          rsel_nxt  = full_e;
          ridx_nxt  = 2'd0;
        end else if (prefix) begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
          mask_nxt  = cand;
        end else begin
          fidx_nxt    = '0;
          ret_end_nxt = 1'b0;
        end
      end
      ST_FLUSH: begin
        feed.valid = 1'b1;
        feed.ch    = buf_r[fidx_r];
        if (rsp.feed_done) begin
          if (flush_end) begin
            count_nxt = '0;
          end else begin
            fidx_nxt = fidx_r + IW'(1);
          end
        end
      end
      ST_REP: begin
        feed.valid = 1'b1;
        feed.ch    = rep_char(rsel_r, ridx_r);
        if (rsp.feed_done) begin
          ridx_nxt = ridx_r + 2'd1;
        end
      end
      ST_END: begin
        if (last_r && (count_r != '0)) begin
          fidx_nxt    = '0;
          ret_end_nxt = 1'b1;
        end else begin
          fin.valid = 1'b1;
          if (rsp.fin_done && last_r) begin
            inside_nxt = 1'b0;
            count_nxt  = '0;
          end
        end
      end
      default: begin
        count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      inside_r <= 1'b0;
      count_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      inside_r <= inside_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r    <= last_nxt;
    cur_r     <= cur_nxt;
    mask_r    <= mask_nxt;
    fidx_r    <= fidx_nxt;
    ret_end_r <= ret_end_nxt;
    rsel_r    <= rsel_nxt;
    ridx_r    <= ridx_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_r[wr_idx] <= cur_r;
    end
  end

  `HTSED_ASSERT_IMP(a_count_bound, 1'b1, int'(count_r) <= DEPTH, "look-ahead count beyond buffer depth")
  `HTSED_ASSERT_IMP(a_rep_empty_buf, state_r == ST_REP, count_r == '0, "replacement while bytes remain buffered")
  `HTSED_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready && (state_r != ST_IDLE), "sequencer idle right after a transfer")

endmodule

@@ rtl/core/html_tag_strip_entity_decode_top.sv @@
// Top level of the HTML text extractor: tag stripping, entity decoding and
// whitespace collapsing. Uses htsed_pkg, htsed_seq and htsed_emit.
//
//  Channel  Direction  Handshake              Payload
//  in_      input      in_valid / in_ready    in_byte[7:0], in_last
//  out_     output     out_valid / out_ready  out_byte[7:0], out_has_char, out_last
//
// A plain byte passes through the transfer, a decode step and a closing step
// that hands the held result to the output register; a byte dropped inside a
// tag skips the decode step. A completed entity takes a matching step and then
// feeds each replacement byte. A broken entity takes a step to see the
// mismatch, replays each buffered byte and then decodes the new byte. The last
// byte of a document adds a flush of any bytes still buffered, and each
// collapsed space written before a character is fed as its own item first.
// Reset is synchronous on rst_n, active low, and clears all control state; no
// clearing pass is needed. A stalled output stalls the emitter once a result
// is held, and the sequencer waits; in_ready is high only while no byte is in work.
module html_tag_strip_entity_decode_top import htsed_pkg::*; #(
  parameter int ENTITY_BUFFER_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_has_char,
  output logic       out_last
);

  // The sequencer turns each byte into a series of characters for the
  // emitter, then asks it to close the item; the last item of a document
  // also flushes any half-read entity first.
  feed_req_t feed;
  fin_req_t  fin;
  emit_rsp_t rsp;

  htsed_seq #(
    .DEPTH(ENTITY_BUFFER_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .feed     (feed),
    .fin      (fin),
    .rsp      (rsp)
  );

  // The emitter keeps one result in hand so that the final result of a
  // document can carry out_last, and it owns the output register that lets
  // a finished result wait while work goes on.
  htsed_emit u_emit (
    .clk          (clk),
    .rst_n        (rst_n),
    .feed         (feed),
    .fin          (fin),
    .rsp          (rsp),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_has_char (out_has_char),
    .out_last     (out_last)
  );

endmodule
